// ----- rtl/websocket_frame_deframer_unit_assert.svh -----
// Assertion macros used by the checker file.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define WSFD_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("wsfd same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define WSFD_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("wsfd next-cycle check failed");

`endif

// ----- rtl/wsfd_pkg.sv -----
package wsfd_pkg;

  // payload length counter width
  localparam int LEN_W  = 17;
  // max_payload register width
  localparam int MAXP_W = 17;

  localparam logic [MAXP_W-1:0] MAXP_RESET = MAXP_W'(64 * 1024);
  localparam logic [LEN_W-1:0]  CTRL_MAX_LEN = LEN_W'(125);

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [2:0] VERD_NONE       = 3'd0;
  localparam logic [2:0] VERD_PONG_IGN   = 3'd1;
  localparam logic [2:0] VERD_PONG_ECHO  = 3'd2;
  localparam logic [2:0] VERD_CLOSE_ECHO = 3'd3;
  localparam logic [2:0] VERD_CLOSE_1008 = 3'd4;
  localparam logic [2:0] VERD_PROTO      = 3'd5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       conn_start;
  } item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic [3:0] frame_opcode;
    logic       frame_last;
    logic [2:0] verdict;
  } result_t;

endpackage

// ----- rtl/wsfd_parser.sv -----
// Frame parser: header/length/mask state and payload unmasking, one byte per request.
module wsfd_parser import wsfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [MAXP_W-1:0] cfg_wdata,
  input  logic              accept,
  input  item_t             item,
  output logic              res_valid,
  output result_t           res
);

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  logic [MAXP_W-1:0] max_payload;
  phase_t            phase, phase_next;
  logic [3:0]        frame_op, frame_op_next;
  logic              fin_flag, fin_flag_next;
  logic              reserved_seen, reserved_seen_next;
  logic              mask_flag, mask_flag_next;
  logic [3:0]        ext_bytes_left, ext_bytes_left_next;
  logic              length_over, length_over_next;
  logic [LEN_W-1:0]  bytes_left, bytes_left_next;
  logic [31:0]       mask_key, mask_key_next;
  logic [1:0]        key_index, key_index_next;
  logic              dead, dead_next;

  // state as seen after an optional connection-start clear
  phase_t            ph_c;
  logic [3:0]        op_c, ext_c;
  logic              fin_c, rsv_c, msk_c, over_c, dead_c;
  logic [LEN_W-1:0]  bl_c;
  logic [31:0]       key_c;
  logic [1:0]        ki_c;

  logic [7:0]        b;
  logic [LEN_W+7:0]  ext_wide;
  logic [LEN_W-1:0]  len_chk;
  logic              over_chk;
  logic              bad;
  logic [2:0]        fv;
  logic [7:0]        kbyte;

  assign b = item.in_byte;

  always_comb begin
    if (item.conn_start) begin
      ph_c   = PH_HDR0;
      op_c   = '0;
      fin_c  = 1'b0;
      rsv_c  = 1'b0;
      msk_c  = 1'b0;
      ext_c  = '0;
      over_c = 1'b0;
      bl_c   = '0;
      key_c  = '0;
      ki_c   = '0;
      dead_c = 1'b0;
    end else begin
      ph_c   = phase;
      op_c   = frame_op;
      fin_c  = fin_flag;
      rsv_c  = reserved_seen;
      msk_c  = mask_flag;
      ext_c  = ext_bytes_left;
      over_c = length_over;
      bl_c   = bytes_left;
      key_c  = mask_key;
      ki_c   = key_index;
      dead_c = dead;
    end
  end

  // verdict for a frame that completes normally
  always_comb begin
    case (op_c)
      OP_CLOSE: fv = VERD_CLOSE_ECHO;
      OP_PING:  fv = VERD_PONG_ECHO;
      OP_PONG:  fv = VERD_PONG_IGN;
      default:  fv = VERD_CLOSE_1008;
    endcase
  end

  assign ext_wide = {bl_c, b};
  assign kbyte    = 8'(key_c >> {~ki_c, 3'b000});

  always_comb begin
    phase_next          = ph_c;
    frame_op_next       = op_c;
    fin_flag_next       = fin_c;
    reserved_seen_next  = rsv_c;
    mask_flag_next      = msk_c;
    ext_bytes_left_next = ext_c;
    length_over_next    = over_c;
    bytes_left_next     = bl_c;
    mask_key_next       = key_c;
    key_index_next      = ki_c;
    dead_next           = dead_c;
    res_valid           = 1'b0;
    res                 = '{data_byte: 8'h00, data_valid: 1'b0, frame_opcode: op_c,
                            frame_last: 1'b0, verdict: VERD_NONE};
    len_chk             = '0;
    over_chk            = over_c;
    bad                 = 1'b0;

    if (accept && !dead_c) begin
      case (ph_c)
        PH_HDR0: begin
          frame_op_next      = b[3:0];
          fin_flag_next      = b[7];
          reserved_seen_next = (b[6:4] != 3'b000);
          phase_next         = PH_HDR1;
        end
        PH_HDR1: begin
          mask_flag_next   = b[7];
          length_over_next = 1'b0;
          over_chk         = 1'b0;
          if (b[6:0] == LEN7_EXT16) begin
            bytes_left_next     = '0;
            ext_bytes_left_next = 4'd2;
            phase_next          = PH_EXT;
          end else if (b[6:0] == LEN7_EXT64) begin
            bytes_left_next     = '0;
            ext_bytes_left_next = 4'd8;
            phase_next          = PH_EXT;
          end else begin
            len_chk         = LEN_W'(b[6:0]);
            bytes_left_next = len_chk;
            bad = !fin_c || rsv_c || !b[7] || (len_chk > max_payload) ||
                  (op_c[3] && (len_chk > CTRL_MAX_LEN));
            if (bad) begin
              dead_next = 1'b1;
              res_valid = 1'b1;
              res.frame_last = 1'b1;
              res.verdict    = VERD_PROTO;
            end else begin
              phase_next     = PH_MASK;
              key_index_next = '0;
              mask_key_next  = '0;
            end
          end
        end
        PH_EXT: begin
          // bits shifted out of the counter make the length sticky-over
          over_chk            = over_c || (bl_c[LEN_W-1:LEN_W-8] != 8'h00);
          length_over_next    = over_chk;
          len_chk             = ext_wide[LEN_W-1:0];
          bytes_left_next     = len_chk;
          ext_bytes_left_next = ext_c - 4'd1;
          if (ext_bytes_left_next == 4'd0) begin
            bad = !fin_c || rsv_c || !msk_c || over_chk || (len_chk > max_payload) ||
                  (op_c[3] && (len_chk > CTRL_MAX_LEN));
            if (bad) begin
              dead_next = 1'b1;
              res_valid = 1'b1;
              res.frame_last = 1'b1;
              res.verdict    = VERD_PROTO;
            end else begin
              phase_next     = PH_MASK;
              key_index_next = '0;
              mask_key_next  = '0;
            end
          end
        end
        PH_MASK: begin
          mask_key_next  = {key_c[23:0], b};
          key_index_next = ki_c + 2'd1;
          if (key_index_next == 2'd0) begin
            if (bl_c == '0) begin
              // empty payload: verdict only
              res_valid      = 1'b1;
              res.frame_last = 1'b1;
              res.verdict    = fv;
              phase_next     = PH_HDR0;
              if (fv >= VERD_CLOSE_ECHO) dead_next = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          key_index_next  = ki_c + 2'd1;
          bytes_left_next = bl_c - LEN_W'(1);
          res_valid       = 1'b1;
          res.data_byte   = b ^ kbyte;
          res.data_valid  = 1'b1;
          if (bytes_left_next == '0) begin
            res.frame_last = 1'b1;
            res.verdict    = fv;
            phase_next     = PH_HDR0;
            if (fv >= VERD_CLOSE_ECHO) dead_next = 1'b1;
          end
        end
        default: phase_next = PH_HDR0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload    <= MAXP_RESET;
      phase          <= PH_HDR0;
      frame_op       <= '0;
      fin_flag       <= 1'b0;
      reserved_seen  <= 1'b0;
      mask_flag      <= 1'b0;
      ext_bytes_left <= '0;
      length_over    <= 1'b0;
      bytes_left     <= '0;
      mask_key       <= '0;
      key_index      <= '0;
      dead           <= 1'b0;
    end else begin
      if (cfg_we) max_payload <= cfg_wdata;
      if (accept) begin
        phase          <= phase_next;
        frame_op       <= frame_op_next;
        fin_flag       <= fin_flag_next;
        reserved_seen  <= reserved_seen_next;
        mask_flag      <= mask_flag_next;
        ext_bytes_left <= ext_bytes_left_next;
        length_over    <= length_over_next;
        bytes_left     <= bytes_left_next;
        mask_key       <= mask_key_next;
        key_index      <= key_index_next;
        dead           <= dead_next;
      end
    end
  end

endmodule

// ----- rtl/websocket_frame_deframer_unit.sv -----
// WebSocket client-to-server deframer. One stream byte per request on the item
// channel; the block accepts a new byte every cycle while item_ready is high, and
// each result is registered into the result register or the skid entry. A byte
// gives zero or one result: header, length and mask-key bytes give none, each
// payload byte gives its unmasked value, and the last result of a frame carries
// the verdict (empty frames and protocol errors give one data-less verdict).
// Verdicts close-echo, close-1008 and protocol-error make the block drop all
// bytes until a byte with conn_start set. A two-entry output buffer (result
// register plus skid) lets input flow on after the result side stalls until a
// result fills the skid; sustained rate is one byte per cycle while result_ready
// is high. max_payload is written through cfg_we/cfg_wdata and resets to 65536;
// the user must write it only while the block is idle; the block does not check.
module websocket_frame_deframer_unit import wsfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [MAXP_W-1:0] cfg_wdata,
  input  logic              item_valid,
  output logic              item_ready,
  input  item_t             item,
  output logic              result_valid,
  input  logic              result_ready,
  output result_t           result
);

  logic    accept;
  logic    res_valid;
  result_t res;

  // output register plus one skid entry
  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  logic    out_fire;

  // input stalls only once the skid entry is occupied
  assign item_ready = !skid_valid;
  assign accept     = item_valid && item_ready;
  assign out_fire   = out_valid && result_ready;

  wsfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        // no new request can arrive while the skid is full
        if (out_fire) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end
      end else if (accept && res_valid) begin
        if (out_valid && !result_ready) begin
          skid_data  <= res;
          skid_valid <= 1'b1;
        end else begin
          out_data  <= res;
          out_valid <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result_valid = out_valid;
  assign result       = out_data;

endmodule

// ----- rtl/wsfd_checker.sv -----
`include "websocket_frame_deframer_unit_assert.svh"

module wsfd_checker import wsfd_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // stalled result holds
  `WSFD_ASSERT_NEXT(a_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result))

  // verdict only on the last result of a frame
  `WSFD_ASSERT_IMPLY(a_mid_no_verdict, clk, rst, result_valid && !result.frame_last, result.verdict == VERD_NONE)

  // a data-less result is a frame end with a zero data byte
  `WSFD_ASSERT_IMPLY(a_nodata_last, clk, rst, result_valid && !result.data_valid, result.frame_last && result.data_byte == 8'h00)

  // frame end always has a real verdict
  `WSFD_ASSERT_IMPLY(a_last_verdict, clk, rst, result_valid && result.frame_last, result.verdict != VERD_NONE && result.verdict <= VERD_PROTO)

endmodule

bind websocket_frame_deframer_unit wsfd_checker u_wsfd_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
